// ===== rtl/slbt_pkg.sv =====
// Shared types and constants for the spectrum band level tracker.
`default_nettype none
package slbt_pkg;

  localparam int unsigned SUM_W   = 43;
  localparam int unsigned LVL_W   = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SR_W    = 18;
  localparam int unsigned FSZ_W   = 13;
  localparam int unsigned HZ_W    = 12;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 18;
  localparam int unsigned NBANDS  = 3;

  localparam logic [HZ_W-1:0] HZ_BASS = 12'd761;
  localparam logic [HZ_W-1:0] HZ_MID  = 12'd2897;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SAMPLE_RATE  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_SIZE   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_ATTACK_GAIN  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RELEASE_GAIN = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_PEAK_DECAY   = 3'd4;

  // Input actions
  localparam logic ACT_BIN   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              action;
    logic [LVL_W-1:0]  bin_value;
  } in_t;

  typedef struct packed {
    logic [LVL_W-1:0] bass_level;
    logic [LVL_W-1:0] mid_level;
    logic [LVL_W-1:0] treble_level;
    logic [LVL_W-1:0] bass_peak;
    logic [LVL_W-1:0] mid_peak;
    logic [LVL_W-1:0] treble_peak;
  } out_t;

  typedef struct packed {
    logic [SR_W-1:0]   rate_hz;
    logic [FSZ_W-1:0]  frame_size;
    logic [GAIN_W-1:0] attack_gain;
    logic [GAIN_W-1:0] release_gain;
    logic [GAIN_W-1:0] peak_decay;
  } cfg_t;

  // Command from front to back: a query or a finished frame with its sums
  typedef struct packed {
    logic             is_query;
    logic [SUM_W-1:0] bass_total;
    logic [SUM_W-1:0] sum_mid;
    logic [SUM_W-1:0] sum_treble;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/spectrum_band_level_tracker.sv =====
// Top level of the three-band spectrum level tracker.
// Input channel (in_valid_i/in_stall_o/in_data_i) takes one item per cycle when not stalled:
// a spectrum bin of the current frame, or a query. Bins are taken in order
// and summed into bass, mid and treble by band edges derived from the
// sample rate and frame size registers.
// Output channel (out_valid_o/out_stall_i/out_data_o) carries the six levels
// once per frame (at its last bin) and once per query.
// Bins stream at one per cycle while input is not stalled. At a frame end the back
// end forms the three band averages with the shared one-bit-per-cycle divider,
// one band after another; a query skips the divider. A two-entry queue
// lets bins keep flowing meanwhile; input stalls when it is full.
// After reset and after any register write the band edges are recomputed by
// a second serial divider, bass edge then mid edge, during which input stalls.
// When the receiver stalls, the result is held in the output register and
// the back end waits; the queue then fills and stalls the input.
// The user must write registers only while the block is idle; the block does not enforce it.
`default_nettype none
module spectrum_band_level_tracker #(
  parameter int unsigned MAX_FRAME_SIZE = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [slbt_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [slbt_pkg::CDATA_W-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  slbt_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output slbt_pkg::out_t                     out_data_o
);
  import slbt_pkg::*;

  localparam int unsigned FS_W = $clog2(MAX_FRAME_SIZE) + 1;

  cfg_t            cfg_q;
  logic            push, full, empty, pop;
  cmd_t            push_cmd, head;
  logic [FS_W-1:0] cnt_b, cnt_m, cnt_t;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_hz      <= SR_W'(44100);
      cfg_q.frame_size   <= FSZ_W'(1024);
      cfg_q.attack_gain  <= GAIN_W'(58982);
      cfg_q.release_gain <= GAIN_W'(9830);
      cfg_q.peak_decay   <= GAIN_W'(65208);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_RATE:  cfg_q.rate_hz      <= cfg_data_i[SR_W-1:0];
        CFG_FRAME_SIZE:   cfg_q.frame_size   <= cfg_data_i[FSZ_W-1:0];
        CFG_ATTACK_GAIN:  cfg_q.attack_gain  <= cfg_data_i[GAIN_W-1:0];
        CFG_RELEASE_GAIN: cfg_q.release_gain <= cfg_data_i[GAIN_W-1:0];
        CFG_PEAK_DECAY:   cfg_q.peak_decay   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  slbt_front #(.MAX_FRAME_SIZE(MAX_FRAME_SIZE)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cfg_wr_i     (cfg_we_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .full_i       (full),
    .cnt_bass_o   (cnt_b),
    .cnt_mid_o    (cnt_m),
    .cnt_treble_o (cnt_t)
  );

  slbt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  slbt_back #(.FS_W(FS_W)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cnt_bass_i   (cnt_b),
    .cnt_mid_i    (cnt_m),
    .cnt_treble_i (cnt_t),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );
endmodule
`default_nettype wire

// ===== rtl/slbt_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module slbt_div #(
  parameter int unsigned N_W = 43,
  parameter int unsigned D_W = 13
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] num_i,
  input  wire logic [D_W-1:0] den_i,
  output logic                done_o,
  output logic [N_W-1:0]      quo_o
);
  localparam int unsigned C_W = $clog2(N_W + 1);

  logic [C_W-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [D_W-1:0] rem_q, rem_d;
  logic [D_W-1:0] den_q, den_d;
  logic [N_W-1:0] quo_q, quo_d;
  logic [D_W:0]   trial, diff;
  logic           ge;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial  = {rem_q, quo_q[N_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_d = {quo_q[N_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == C_W'(N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/slbt_queue.sv =====
// Two-entry command queue between front and back.
`default_nettype none
module slbt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  slbt_pkg::cmd_t     push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output slbt_pkg::cmd_t     head_o
);
  import slbt_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rp_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= push_cmd_i;
  end
endmodule
`default_nettype wire

// ===== rtl/slbt_front.sv =====
// Front end: band edges from configuration, bin accumulation, command issue.
`default_nettype none
module slbt_front #(
  parameter int unsigned MAX_FRAME_SIZE = 4096,
  localparam int unsigned FS_W  = $clog2(MAX_FRAME_SIZE) + 1,
  localparam int unsigned CNT_W = ($clog2(MAX_FRAME_SIZE) > 1) ?
                                  $clog2(MAX_FRAME_SIZE) - 1 : 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  slbt_pkg::cfg_t      cfg_i,
  input  wire logic           cfg_wr_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  slbt_pkg::in_t       in_data_i,
  output logic                push_o,
  output slbt_pkg::cmd_t      push_cmd_o,
  input  wire logic           full_i,
  output logic [FS_W-1:0]     cnt_bass_o,
  output logic [FS_W-1:0]     cnt_mid_o,
  output logic [FS_W-1:0]     cnt_treble_o
);
  import slbt_pkg::*;

  localparam int unsigned CMP_W = (FS_W > FSZ_W) ? FS_W : FSZ_W;
  localparam int unsigned EN_W  = HZ_W + FS_W;

  localparam logic [1:0] S_START = 2'd0;
  localparam logic [1:0] S_BASS  = 2'd1;
  localparam logic [1:0] S_MID   = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [1:0]       st_q, st_d;
  logic [FS_W-1:0]  bass_end_q, mid_end_q;
  logic [CNT_W-1:0] idx_q;
  logic [SUM_W-1:0] sb_q, sm_q, st_sum_q;
  logic [SUM_W-1:0] sb_n, sm_n, st_n;

  logic [CMP_W-1:0] fs_ext, fs_cap;
  logic [FS_W-1:0]  fs_eff, nbins, nb2, edge_val;
  logic [HZ_W-1:0]  hz;
  logic             div_start, div_done, accept, last;
  logic [EN_W-1:0]  div_quo;
  logic [FS_W-1:0]  idx_ext, idx_inc;

  // Bins per frame from the clamped frame size
  always_comb begin
    fs_ext = CMP_W'(cfg_i.frame_size);
    fs_cap = (fs_ext > CMP_W'(MAX_FRAME_SIZE)) ? CMP_W'(MAX_FRAME_SIZE) : fs_ext;
    fs_eff = fs_cap[FS_W-1:0];
    nbins  = (fs_eff[FS_W-1:1] == '0) ? FS_W'(1) : {1'b0, fs_eff[FS_W-1:1]};
    nb2    = {nbins[FS_W-2:0], 1'b0};
  end

  // Edge sequencer: recompute both edges after reset or any write
  always_comb begin
    st_d      = st_q;
    div_start = 1'b0;
    hz        = HZ_BASS;
    case (st_q)
      S_START: begin
        div_start = 1'b1;
        st_d      = S_BASS;
      end
      S_BASS: begin
        if (div_done) begin
          div_start = 1'b1;
          hz        = HZ_MID;
          st_d      = S_MID;
        end
      end
      S_MID: begin
        if (div_done) st_d = S_RUN;
      end
      S_RUN: st_d = S_RUN;
      default: st_d = S_START;
    endcase
    if (cfg_wr_i) begin
      st_d      = S_START;
      div_start = 1'b0;
    end
  end

  slbt_div #(.N_W(EN_W), .D_W(SR_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (EN_W'(hz) * EN_W'(nb2)),
    .den_i   (cfg_i.rate_hz),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Clamp the edge to the frame; a zero rate puts every bin in bass
  always_comb begin
    if (cfg_i.rate_hz == '0) edge_val = nbins;
    else if (div_quo > EN_W'(nbins)) edge_val = nbins;
    else edge_val = div_quo[FS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_START;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_BASS && div_done) bass_end_q <= edge_val;
    if (st_q == S_MID && div_done) mid_end_q <= edge_val;
  end

  assign cnt_bass_o   = bass_end_q;
  assign cnt_mid_o    = (mid_end_q > bass_end_q) ? mid_end_q - bass_end_q : '0;
  assign cnt_treble_o = nbins - mid_end_q;

  // Accept only with valid edges and room in the queue
  assign in_stall_o = !(st_q == S_RUN) || full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the bin and accumulate into its band
  always_comb begin
    idx_ext = FS_W'(idx_q);
    idx_inc = idx_ext + 1'b1;
    last    = !(idx_inc < nbins);
    sb_n    = sb_q;
    sm_n    = sm_q;
    st_n    = st_sum_q;
    if (idx_ext < bass_end_q) sb_n = sb_q + SUM_W'(in_data_i.bin_value);
    else if (idx_ext < mid_end_q) sm_n = sm_q + SUM_W'(in_data_i.bin_value);
    else st_n = st_sum_q + SUM_W'(in_data_i.bin_value);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      sb_q     <= '0;
      sm_q     <= '0;
      st_sum_q <= '0;
    end else if (accept && in_data_i.action == ACT_BIN) begin
      if (last) begin
        idx_q    <= '0;
        sb_q     <= '0;
        sm_q     <= '0;
        st_sum_q <= '0;
      end else begin
        idx_q    <= idx_inc[CNT_W-1:0];
        sb_q     <= sb_n;
        sm_q     <= sm_n;
        st_sum_q <= st_n;
      end
    end
  end

  // Issue a command on a query or on the last bin of a frame
  assign push_o = accept && (in_data_i.action == ACT_QUERY || last);
  always_comb begin
    push_cmd_o.is_query   = in_data_i.action == ACT_QUERY;
    push_cmd_o.bass_total = sb_n;
    push_cmd_o.sum_mid    = sm_n;
    push_cmd_o.sum_treble = st_n;
  end
endmodule
`default_nettype wire

// ===== rtl/slbt_back.sv =====
// Back end: band averages, smoothing, peak hold and the result register.
`default_nettype none
module slbt_back #(
  parameter int unsigned FS_W = 13
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  slbt_pkg::cfg_t    cfg_i,
  input  wire logic [FS_W-1:0] cnt_bass_i,
  input  wire logic [FS_W-1:0] cnt_mid_i,
  input  wire logic [FS_W-1:0] cnt_treble_i,
  input  wire logic         empty_i,
  input  slbt_pkg::cmd_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output slbt_pkg::out_t    out_data_o
);
  import slbt_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_START = 3'd1;
  localparam logic [2:0] B_WAIT  = 3'd2;
  localparam logic [2:0] B_UPD   = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [1:0]       sel_q;
  cmd_t             cmd_q;
  logic [LVL_W-1:0] avg_q [NBANDS];
  logic [LVL_W-1:0] lvl_q [NBANDS];
  logic [LVL_W-1:0] pk_q  [NBANDS];
  logic [LVL_W-1:0] lvl_n [NBANDS];
  logic [LVL_W-1:0] pk_n  [NBANDS];
  logic             out_valid_q;
  out_t             out_data_q;
  logic             out_free;

  logic [SUM_W-1:0] div_num, div_quo;
  logic [FS_W-1:0]  div_den;
  logic             div_done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (st_q == B_IDLE) && !empty_i;

  // Pick the band being divided
  always_comb begin
    case (sel_q)
      2'd0: begin
        div_num = cmd_q.bass_total;
        div_den = cnt_bass_i;
      end
      2'd1: begin
        div_num = cmd_q.sum_mid;
        div_den = cnt_mid_i;
      end
      default: begin
        div_num = cmd_q.sum_treble;
        div_den = cnt_treble_i;
      end
    endcase
  end

  slbt_div #(.N_W(SUM_W), .D_W(FS_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == B_START),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Smooth each level and decay or raise each peak
  always_comb begin
    for (int i = 0; i < NBANDS; i++) begin
      logic [LVL_W+GAIN_W-1:0] prod_l;
      logic [LVL_W+GAIN_W-1:0] prod_p;
      prod_p = (LVL_W+GAIN_W)'(pk_q[i]) * (LVL_W+GAIN_W)'(cfg_i.peak_decay);
      if (avg_q[i] > lvl_q[i]) begin
        prod_l   = (LVL_W+GAIN_W)'(avg_q[i] - lvl_q[i]) *
                   (LVL_W+GAIN_W)'(cfg_i.attack_gain);
        lvl_n[i] = lvl_q[i] + prod_l[LVL_W+GAIN_W-1:GAIN_W];
      end else begin
        prod_l   = (LVL_W+GAIN_W)'(lvl_q[i] - avg_q[i]) *
                   (LVL_W+GAIN_W)'(cfg_i.release_gain);
        lvl_n[i] = lvl_q[i] - prod_l[LVL_W+GAIN_W-1:GAIN_W];
      end
      pk_n[i] = (avg_q[i] > pk_q[i]) ? avg_q[i] : prod_p[LVL_W+GAIN_W-1:GAIN_W];
    end
  end

  // Sequence: pop, divide three bands and update (frames only), emit
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: begin
        if (!empty_i) st_d = head_i.is_query ? B_OUT : B_START;
      end
      B_START: st_d = B_WAIT;
      B_WAIT: begin
        if (div_done) st_d = (sel_q == 2'd2) ? B_UPD : B_START;
      end
      B_UPD: st_d = B_OUT;
      B_OUT: begin
        if (out_free) st_d = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      sel_q       <= 2'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NBANDS; i++) begin
        lvl_q[i] <= '0;
        pk_q[i]  <= '0;
      end
    end else begin
      st_q <= st_d;
      if (pop_o) sel_q <= 2'd0;
      else if (st_q == B_WAIT && div_done) sel_q <= sel_q + 2'd1;
      if (st_q == B_UPD) begin
        for (int i = 0; i < NBANDS; i++) begin
          lvl_q[i] <= lvl_n[i];
          pk_q[i]  <= pk_n[i];
        end
      end
      if (st_q == B_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= head_i;
    // Empty band averages to zero
    if (st_q == B_WAIT && div_done) avg_q[sel_q] <= (div_den == '0) ? '0 : div_quo[LVL_W-1:0];
    if (st_q == B_OUT && out_free) begin
      out_data_q.bass_level   <= lvl_q[0];
      out_data_q.mid_level    <= lvl_q[1];
      out_data_q.treble_level <= lvl_q[2];
      out_data_q.bass_peak    <= pk_q[0];
      out_data_q.mid_peak     <= pk_q[1];
      out_data_q.treble_peak  <= pk_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the three-band spectrum level tracker: predicted levels checked per result.
`timescale 1ns / 100ps

module testbench;
  import slbt_pkg::*;

  // Level predictor and store of expected results
  class level_scoreboard;
    logic [SR_W-1:0]   rate_hz;
    logic [FSZ_W-1:0]  frame_size;
    logic [GAIN_W-1:0] attack_gain;
    logic [GAIN_W-1:0] release_gain;
    logic [GAIN_W-1:0] peak_decay;
    longint unsigned   bin_idx;
    longint unsigned   bass_total, sum_mid, sum_treble;
    out_t              levels;
    out_t              expected_levels[$];
    int                mismatches;

    function new();
      rate_hz      = 18'd44100;
      frame_size   = 13'd1024;
      attack_gain  = 16'd58982;
      release_gain = 16'd9830;
      peak_decay   = 16'd65208;
      bin_idx      = 0;
      bass_total   = 0;
      sum_mid      = 0;
      sum_treble   = 0;
      levels       = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
      case (idx)
        CFG_SAMPLE_RATE:  rate_hz      = val[SR_W-1:0];
        CFG_FRAME_SIZE:   frame_size   = val[FSZ_W-1:0];
        CFG_ATTACK_GAIN:  attack_gain  = val[GAIN_W-1:0];
        CFG_RELEASE_GAIN: release_gain = val[GAIN_W-1:0];
        CFG_PEAK_DECAY:   peak_decay   = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned frame_bins();
      longint unsigned fs;
      fs = frame_size;
      if (fs > 4096) fs = 4096;
      fs = fs >> 1;
      return (fs == 0) ? 1 : fs;
    endfunction

    function longint unsigned band_edge(longint unsigned hz, longint unsigned nb);
      longint unsigned e;
      if (rate_hz == 0) return nb;
      e = (hz * nb * 2) / rate_hz;
      return (e > nb) ? nb : e;
    endfunction

    function logic [31:0] band_avg(longint unsigned sum, longint unsigned cnt);
      if (cnt == 0) return '0;
      return 32'(sum / cnt);
    endfunction

    function logic [31:0] smooth(logic [31:0] cur, logic [31:0] avg);
      longint unsigned c, a;
      c = cur;
      a = avg;
      if (a > c) c = c + (((a - c) * attack_gain) >> 16);
      else       c = c - (((c - a) * release_gain) >> 16);
      return 32'(c);
    endfunction

    function logic [31:0] decay_peak(logic [31:0] pk, logic [31:0] avg);
      longint unsigned p;
      if (avg > pk) return avg;
      p = pk;
      return 32'((p * peak_decay) >> 16);
    endfunction

    // Advance the predictor by one accepted item
    function void note_item(in_t it);
      longint unsigned nb, be, me;
      logic [31:0] ab, am, at;
      if (it.action == ACT_QUERY) begin
        expected_levels.push_back(levels);
        return;
      end
      nb = frame_bins();
      be = band_edge(longint'(HZ_BASS), nb);
      me = band_edge(longint'(HZ_MID), nb);
      if (bin_idx < be)      bass_total = (bass_total + it.bin_value) & 64'h7FF_FFFF_FFFF;
      else if (bin_idx < me) sum_mid    = (sum_mid + it.bin_value) & 64'h7FF_FFFF_FFFF;
      else                   sum_treble = (sum_treble + it.bin_value) & 64'h7FF_FFFF_FFFF;
      if (bin_idx + 1 < nb) begin
        bin_idx = (bin_idx + 1) & 64'h7FF;
        return;
      end
      ab = band_avg(bass_total, be);
      am = band_avg(sum_mid, (me > be) ? me - be : 0);
      at = band_avg(sum_treble, nb - me);
      levels.bass_level   = smooth(levels.bass_level, ab);
      levels.mid_level    = smooth(levels.mid_level, am);
      levels.treble_level = smooth(levels.treble_level, at);
      levels.bass_peak    = decay_peak(levels.bass_peak, ab);
      levels.mid_peak     = decay_peak(levels.mid_peak, am);
      levels.treble_peak  = decay_peak(levels.treble_peak, at);
      bin_idx    = 0;
      bass_total = 0;
      sum_mid    = 0;
      sum_treble = 0;
      expected_levels.push_back(levels);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      mismatches++;
    endtask

    // Compare one result with the oldest expectation
    task check_levels(out_t got);
      out_t want;
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected result, bass_level", got.bass_level, '0);
        return;
      end
      want = expected_levels.pop_front();
      if (got.bass_level !== want.bass_level)
        report_mismatch("bass_level", got.bass_level, want.bass_level);
      if (got.mid_level !== want.mid_level)
        report_mismatch("mid_level", got.mid_level, want.mid_level);
      if (got.treble_level !== want.treble_level)
        report_mismatch("treble_level", got.treble_level, want.treble_level);
      if (got.bass_peak !== want.bass_peak)
        report_mismatch("bass_peak", got.bass_peak, want.bass_peak);
      if (got.mid_peak !== want.mid_peak)
        report_mismatch("mid_peak", got.mid_peak, want.mid_peak);
      if (got.treble_peak !== want.treble_peak)
        report_mismatch("treble_peak", got.treble_peak, want.treble_peak);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CIDX_W-1:0]  cfg_idx_i;
  logic [CDATA_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_t               out_data_o;

  level_scoreboard levels_sb;
  int              idle_mode;

  spectrum_band_level_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check accepted results and stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) levels_sb.check_levels(out_data_o);
      case (idle_mode)
        2:       out_stall_i <= ($urandom_range(99) < 56);
        3:       out_stall_i <= ($urandom_range(99) < 13);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Send one item, idling beforehand at random
  task automatic send_item(logic act, logic [31:0] val);
    in_t it;
    int  pct;
    pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 13 : 0;
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    it.action    = act;
    it.bin_value = val;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    levels_sb.note_item(it);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    levels_sb.set_reg(idx, val);
  endtask

  // Hold until the block is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (levels_sb.expected_levels.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic configure(int sr, int fs, int ag, int rg, int pd);
    drain();
    write_reg(CFG_SAMPLE_RATE, CDATA_W'(sr));
    write_reg(CFG_FRAME_SIZE, CDATA_W'(fs));
    write_reg(CFG_ATTACK_GAIN, CDATA_W'(ag));
    write_reg(CFG_RELEASE_GAIN, CDATA_W'(rg));
    write_reg(CFG_PEAK_DECAY, CDATA_W'(pd));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_bin();
    int k;
    k = $urandom_range(99);
    if (k < 15) return 32'hFFFF_FFFF;
    if (k < 25) return 32'h0;
    if (k < 50) return 32'($urandom_range(1 << 20));
    return 32'($urandom);
  endfunction

  task automatic random_phase(int count, int mode);
    idle_mode = mode;
    repeat (count) begin
      if ($urandom_range(99) < 4) send_item(ACT_QUERY, $urandom);
      else                        send_item(ACT_BIN, random_bin());
    end
  endtask

  initial begin
    levels_sb   = new();
    idle_mode   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: query at reset, then an eight-bin frame with bands 1/4/3
    send_item(ACT_QUERY, 32'h0);
    configure(8000, 16, 65535, 0, 0);
    send_item(ACT_QUERY, 32'hFFFF_FFFF);
    repeat (8) send_item(ACT_BIN, 32'hFFFF_FFFF);
    repeat (3) send_item(ACT_BIN, 32'h0);
    send_item(ACT_QUERY, 32'h0);
    repeat (5) send_item(ACT_BIN, 32'h0);
    repeat (2) send_item(ACT_BIN, 32'h8000_0001);
    send_item(ACT_QUERY, 32'h0);
    // Leave a partial frame, then recompute the edges under it
    repeat (3) send_item(ACT_BIN, 32'h0001_0000);

    configure(8000, 16, 0, 65535, 65535);
    random_phase(200, 0);
    // Bass and mid empty at a 192 kHz rate
    configure(192000, 64, 30000, 20000, 60000);
    random_phase(200, 1);
    // Zero rate: every bin is bass
    configure(0, 20, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    random_phase(120, 2);
    // Tiny frames: one bin each, edges past the frame, then at zero
    configure(17, 2, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    random_phase(100, 3);
    configure(262143, 1, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    random_phase(80, 0);
    configure(22050, 301, 40000, 40000, 40000);
    random_phase(200, 2);
    // Oversized frame clamps to the largest size
    configure(96000, 8191, 58982, 9830, 65208);
    random_phase(600, 3);
    // Shrink the frame so the long partial frame ends on the next bin
    configure(44100, 16, 65535, 65535, 0);
    random_phase(125, 1);

    drain();
    if (levels_sb.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Give up after a generous time
  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
